// ===== sv/accalu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accalu_pkg
// Types and constants for the 8-bit CPU accumulator ALU with flags.
// ----------------------------------------------------------------------------
package accalu_pkg;

  // operation codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC8  = 5'd8;
  localparam logic [4:0] OP_DEC8  = 5'd9;
  localparam logic [4:0] OP_RLCA  = 5'd10;
  localparam logic [4:0] OP_RRCA  = 5'd11;
  localparam logic [4:0] OP_RLA   = 5'd12;
  localparam logic [4:0] OP_RRA   = 5'd13;
  localparam logic [4:0] OP_CPL   = 5'd14;
  localparam logic [4:0] OP_SCF   = 5'd15;
  localparam logic [4:0] OP_CCF   = 5'd16;
  localparam logic [4:0] OP_ADD16 = 5'd17;
  localparam logic [4:0] OP_ADDSP = 5'd18;
  localparam logic [4:0] OP_INC16 = 5'd19;
  localparam logic [4:0] OP_DEC16 = 5'd20;

  // flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [4:0]  func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [3:0]  flags_in;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } rsp_t;

endpackage

// ===== sv/accalu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accalu_core
// Single-pass ALU datapath: one operation, result value and new flags.
// ----------------------------------------------------------------------------
module accalu_core
  import accalu_pkg::*;
(
  input  req_t req,
  output rsp_t rsp
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        add_cin;
  logic        sub_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] sum16;
  logic [12:0] half16;
  logic [15:0] sp_sum;
  logic [15:0] r;
  logic [3:0]  f;

  assign a   = req.operand_a[7:0];
  assign b   = req.operand_b[7:0];
  assign cin = req.flags_in[FLAG_C];

  // carry only feeds in for ADC / SBC
  assign add_cin = (req.func == OP_ADC) ? cin : 1'b0;
  assign sub_cin = (req.func == OP_SBC) ? cin : 1'b0;

  assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
  // borrow is the sign bit of the widened difference
  assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};

  assign inc8   = a + 8'd1;
  assign dec8   = a - 8'd1;
  assign sum16  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign half16 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  assign sp_sum = req.operand_a + {{8{b[7]}}, b};

  always_comb begin
    r = req.operand_a;
    f = req.flags_in;
    unique case (req.func)
      OP_ADD, OP_ADC: begin
        r = {8'd0, add_sum[7:0]};
        f = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
      end
      OP_SUB, OP_SBC: begin
        r = {8'd0, sub_diff[7:0]};
        f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_CP: begin
        r = {8'd0, a};
        f = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
      end
      OP_AND: begin
        r = {8'd0, a & b};
        f = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r = {8'd0, a ^ b};
        f = {(a ^ b) == 8'd0, 3'b000};
      end
      OP_OR: begin
        r = {8'd0, a | b};
        f = {(a | b) == 8'd0, 3'b000};
      end
      OP_INC8: begin
        r = {8'd0, inc8};
        f = {inc8 == 8'd0, 1'b0, a[3:0] == 4'hF, cin};
      end
      OP_DEC8: begin
        r = {8'd0, dec8};
        f = {dec8 == 8'd0, 1'b1, a[3:0] == 4'h0, cin};
      end
      OP_RLCA: begin
        r = {8'd0, a[6:0], a[7]};
        f = {3'b000, a[7]};
      end
      OP_RRCA: begin
        r = {8'd0, a[0], a[7:1]};
        f = {3'b000, a[0]};
      end
      OP_RLA: begin
        r = {8'd0, a[6:0], cin};
        f = {3'b000, a[7]};
      end
      OP_RRA: begin
        r = {8'd0, cin, a[7:1]};
        f = {3'b000, a[0]};
      end
      OP_CPL: begin
        r = {8'd0, ~a};
        f = {req.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        r = {8'd0, a};
        f = {req.flags_in[FLAG_Z], 2'b00, 1'b1};
      end
      OP_CCF: begin
        r = {8'd0, a};
        f = {req.flags_in[FLAG_Z], 2'b00, ~cin};
      end
      OP_ADD16: begin
        r = sum16[15:0];
        f = {req.flags_in[FLAG_Z], 1'b0, half16[12], sum16[16]};
      end
      OP_ADDSP: begin
        // H and C come from the unsigned low-byte add
        r = sp_sum;
        f = {2'b00, add_half[4], add_sum[8]};
      end
      OP_INC16: r = req.operand_a + 16'd1;
      OP_DEC16: r = req.operand_a - 16'd1;
      default: begin
        r = req.operand_a;
        f = req.flags_in;
      end
    endcase
  end

  assign rsp.result    = r;
  assign rsp.flags_out = f;

endmodule

// ===== sv/accumulator_alu_with_flags.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags
// 8-bit CPU ALU with Z/N/H/C flags, plus 16-bit add, SP+offset and inc/dec.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  req     | in        | req_valid/req_stall | func, operands, flags_in
//  rsp     | out       | rsp_valid/rsp_stall | result, flags_out
//
// Throughput one request per cycle while the response side does not stall;
// a request goes through input register, ALU pass and output register in turn
// before its response is shown, with one ALU pass between the two registers.
// rst is synchronous: both stage valid flags clear, payload is left as is.
// rsp_stall holds the output register; the input stage still takes a request
// while it is empty, so req_stall rises only when both stages hold requests.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags
  import accalu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // input stage
  logic in_valid;
  req_t in_req;
  // ALU output
  rsp_t alu_rsp;
  // output stage
  logic out_valid;
  rsp_t out_rsp;

  logic out_load;
  logic in_load;

  // output register takes a new value when empty or being drained
  assign out_load  = !out_valid || !rsp_stall;
  // input register moves on when empty or when its request goes forward
  assign in_load   = !in_valid || out_load;
  assign req_stall = !in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && req_valid) begin
      in_req <= req;
    end
  end

  accalu_core u_core (
    .req (in_req),
    .rsp (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_rsp <= alu_rsp;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = out_rsp;

endmodule

// ===== sv/accalu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accalu_checker
// Port-level checks for the accumulator ALU, bound to the top level.
// ----------------------------------------------------------------------------
module accalu_checker
  import accalu_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // requests are only held off when the output side is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with empty output");

  // an accepted request passes on to the output unless rsp_stall holds it
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
    else $error("response missing after two cycles");

  // 16-bit increment: value and untouched flags
  a_inc16: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.func == OP_INC16) ##1 !rsp_stall |=>
      rsp.result == $past(req.operand_a, 2) + 16'd1 &&
      rsp.flags_out == $past(req.flags_in, 2))
    else $error("inc16 response wrong");

endmodule

bind accumulator_alu_with_flags accalu_checker u_accalu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== dv/accumulator_alu_with_flags_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_checker
// Watches both channels of the ALU, works out the response that each accepted
// request should give and compares it with what comes out, in order.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags_checker
  import accalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int unsigned fail_count,
  output int unsigned pending_count
);

  rsp_t        awaited_rsps[$];
  int unsigned failures = 0;
  int unsigned outstanding = 0;

  assign fail_count    = failures;
  assign pending_count = outstanding;

  // SM83-style ALU behaviour for one request
  function automatic rsp_t alu_outcome(input req_t r);
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [7:0]  v8;
    logic        cin;
    logic        carry_in;
    logic [8:0]  wide9;
    logic [4:0]  nib;
    logic [12:0] wide13;
    logic [16:0] wide17;
    rsp_t        o;
    a8       = r.operand_a[7:0];
    b8       = r.operand_b[7:0];
    cin      = r.flags_in[FLAG_C];
    carry_in = (r.func == OP_ADC || r.func == OP_SBC) ? cin : 1'b0;
    // unused codes and inc16/dec16 leave the flags alone
    o.result    = r.operand_a;
    o.flags_out = r.flags_in;
    case (r.func)
      OP_ADD, OP_ADC: begin
        wide9 = {1'b0, a8} + {1'b0, b8} + {8'd0, carry_in};
        nib   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, carry_in};
        o.result            = {8'h00, wide9[7:0]};
        o.flags_out         = '0;
        o.flags_out[FLAG_Z] = (wide9[7:0] == 8'h00);
        o.flags_out[FLAG_H] = nib[4];
        o.flags_out[FLAG_C] = wide9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        wide9 = {1'b0, a8} - {1'b0, b8} - {8'd0, carry_in};
        nib   = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, carry_in};
        o.result            = (r.func == OP_CP) ? {8'h00, a8} : {8'h00, wide9[7:0]};
        o.flags_out         = '0;
        o.flags_out[FLAG_Z] = (wide9[7:0] == 8'h00);
        o.flags_out[FLAG_N] = 1'b1;
        o.flags_out[FLAG_H] = nib[4];
        o.flags_out[FLAG_C] = wide9[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (r.func == OP_AND) v8 = a8 & b8;
        else if (r.func == OP_XOR) v8 = a8 ^ b8;
        else v8 = a8 | b8;
        o.result            = {8'h00, v8};
        o.flags_out         = '0;
        o.flags_out[FLAG_Z] = (v8 == 8'h00);
        o.flags_out[FLAG_H] = (r.func == OP_AND);
      end
      OP_INC8, OP_DEC8: begin
        v8 = (r.func == OP_INC8) ? a8 + 8'd1 : a8 - 8'd1;
        o.result            = {8'h00, v8};
        o.flags_out[FLAG_Z] = (v8 == 8'h00);
        o.flags_out[FLAG_N] = (r.func == OP_DEC8);
        o.flags_out[FLAG_H] = (r.func == OP_INC8) ? (a8[3:0] == 4'hF) : (a8[3:0] == 4'h0);
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (r.func)
          OP_RLCA: v8 = {a8[6:0], a8[7]};
          OP_RRCA: v8 = {a8[0], a8[7:1]};
          OP_RLA:  v8 = {a8[6:0], cin};
          default: v8 = {cin, a8[7:1]};
        endcase
        o.result            = {8'h00, v8};
        o.flags_out         = '0;
        o.flags_out[FLAG_C] = (r.func == OP_RLCA || r.func == OP_RLA) ? a8[7] : a8[0];
      end
      OP_CPL: begin
        o.result            = {8'h00, ~a8};
        o.flags_out[FLAG_N] = 1'b1;
        o.flags_out[FLAG_H] = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        o.result            = {8'h00, a8};
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_H] = 1'b0;
        o.flags_out[FLAG_C] = (r.func == OP_SCF) ? 1'b1 : ~cin;
      end
      OP_ADD16: begin
        wide17 = {1'b0, r.operand_a} + {1'b0, r.operand_b};
        wide13 = {1'b0, r.operand_a[11:0]} + {1'b0, r.operand_b[11:0]};
        o.result            = wide17[15:0];
        o.flags_out[FLAG_N] = 1'b0;
        o.flags_out[FLAG_H] = wide13[12];
        o.flags_out[FLAG_C] = wide17[16];
      end
      OP_ADDSP: begin
        // offset is signed, carries come from the unsigned low-byte sum
        wide9 = {1'b0, a8} + {1'b0, b8};
        nib   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
        o.result            = r.operand_a + {{8{b8[7]}}, b8};
        o.flags_out         = '0;
        o.flags_out[FLAG_H] = nib[4];
        o.flags_out[FLAG_C] = wide9[8];
      end
      OP_INC16: o.result = r.operand_a + 16'd1;
      OP_DEC16: o.result = r.operand_a - 16'd1;
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) awaited_rsps.push_back(alu_outcome(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          failures++;
          $error("unexpected response: result %h flags_out %h", rsp.result, rsp.flags_out);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.result !== want.result) begin
            failures++;
            $error("result mismatch: expected %h, actual %h", want.result, rsp.result);
          end
          if (rsp.flags_out !== want.flags_out) begin
            failures++;
            $error("flags_out mismatch: expected %b, actual %b", want.flags_out,
                   rsp.flags_out);
          end
        end
      end
    end
    outstanding <= awaited_rsps.size();
  end

endmodule

// ===== dv/accumulator_alu_with_flags_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_alu_with_flags_tb
// Drives ALU requests through the valid/stall channel: a directed set of
// corner cases for every operation, then random requests in bursts, while the
// response side stalls at random and once holds off long enough to back the
// pipeline up. The checker beside the block compares every response.
// ----------------------------------------------------------------------------
module accumulator_alu_with_flags_tb;
  import accalu_pkg::*;

  // highest operation code the field can carry; 21 upwards are unused
  localparam logic [4:0] FUNC_TOP = 5'd31;
  localparam int unsigned RANDOM_REQS = 400;
  // cycles to let the two-stage pipe settle once the queue is empty
  localparam int unsigned TAIL_CYCLES = 6;
  localparam int unsigned DRAIN_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned burst_left = 0;

  accumulator_alu_with_flags i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  accumulator_alu_with_flags_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Response side. A short spell of light stalling, then one long hold-off
  // while the sender keeps offering requests, so both pipeline stages fill
  // and req_stall has to rise. After that: a mix of free-running stretches,
  // random stalling and the odd further hold-off.
  // Every assignment is followed by a clock edge before the next one, so
  // rsp_stall never sees two updates in one step.
  initial begin
    int unsigned span;
    rsp_stall = 1'b0;
    wait (!rst);
    repeat (30) begin
      rsp_stall <= ($urandom_range(0, 3) == 0);
      @(posedge clk);
    end
    rsp_stall <= 1'b1;
    repeat (60) @(posedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          span = $urandom_range(20, 50);
          rsp_stall <= 1'b1;
          repeat (span) @(posedge clk);
        end
        1, 2, 3: begin
          span = $urandom_range(10, 40);
          rsp_stall <= 1'b0;
          repeat (span) @(posedge clk);
        end
        default: begin
          span = $urandom_range(10, 40);
          repeat (span) begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  function automatic req_t make_req(input logic [4:0] f, input logic [15:0] a,
                                    input logic [15:0] b, input logic [3:0] fl);
    req_t r;
    r.func      = f;
    r.operand_a = a;
    r.operand_b = b;
    r.flags_in  = fl;
    return r;
  endfunction

  // operand with the low byte often at a nibble or byte boundary, random top
  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0: v[7:0] = 8'h00;
      1: v[7:0] = 8'hFF;
      2: v[7:0] = 8'h0F;
      3: v[7:0] = 8'h80;
      4: v = 16'hFFFF;
      5: v[11:0] = 12'hFFF;
      default: ;
    endcase
    return v;
  endfunction

  // Offer one request and hold it until taken. Pacing is in bursts: at the
  // start of each burst valid may drop for a random gap; a third of bursts
  // follow on with no gap at all. Valid is only ever lowered ahead of a wait.
  task automatic issue(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin
    req_t        r;
    int unsigned waited;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed corners, one or more per operation ---
    issue(make_req(OP_ADD,   16'h0000, 16'h0000, 4'b0000)); // zero sum
    issue(make_req(OP_ADD,   16'hA50F, 16'h5A01, 4'b1111)); // half carry only
    issue(make_req(OP_ADD,   16'h00FF, 16'hFF01, 4'b0000)); // wraps to zero, H and C
    issue(make_req(OP_ADC,   16'h000E, 16'h0001, 4'b0001)); // carry-in makes H
    issue(make_req(OP_ADC,   16'h00FF, 16'h00FF, 4'b0001));
    issue(make_req(OP_SUB,   16'h1234, 16'h5634, 4'b0000)); // equal low bytes
    issue(make_req(OP_SUB,   16'h0010, 16'h0001, 4'b1111)); // half borrow
    issue(make_req(OP_SBC,   16'h0000, 16'h00FF, 4'b0001)); // full borrow, zero
    issue(make_req(OP_AND,   16'hFFF0, 16'hFF0F, 4'b0101));
    issue(make_req(OP_XOR,   16'h00A5, 16'h00A5, 4'b0111));
    issue(make_req(OP_OR,    16'hFF00, 16'h0000, 4'b0001));
    issue(make_req(OP_CP,    16'hAB3C, 16'hCD40, 4'b0000)); // A kept, upper byte gone
    issue(make_req(OP_INC8,  16'h12FF, 16'h0000, 4'b0001));
    issue(make_req(OP_DEC8,  16'h3400, 16'h0000, 4'b0000));
    issue(make_req(OP_DEC8,  16'h0001, 16'h0000, 4'b0001));
    issue(make_req(OP_RLCA,  16'h0080, 16'h0000, 4'b1110));
    issue(make_req(OP_RRCA,  16'h0001, 16'h0000, 4'b1110));
    issue(make_req(OP_RLA,   16'h0080, 16'h0000, 4'b1110)); // rotates to zero
    issue(make_req(OP_RRA,   16'h0001, 16'h0000, 4'b0001)); // old C goes to bit 7
    issue(make_req(OP_CPL,   16'h775A, 16'h0000, 4'b1001));
    issue(make_req(OP_SCF,   16'hBEEF, 16'h0000, 4'b1110));
    issue(make_req(OP_CCF,   16'h0042, 16'h0000, 4'b1111));
    issue(make_req(OP_ADD16, 16'hFFFF, 16'h0001, 4'b1000));
    issue(make_req(OP_ADD16, 16'h0FFF, 16'h0001, 4'b0111));
    issue(make_req(OP_ADDSP, 16'hFFF8, 16'h1208, 4'b1111)); // positive offset
    issue(make_req(OP_ADDSP, 16'h0000, 16'h00FF, 4'b1111)); // offset of -1
    issue(make_req(OP_INC16, 16'hFFFF, 16'h0000, 4'b1010));
    issue(make_req(OP_DEC16, 16'h0000, 16'h0000, 4'b0101));
    issue(make_req(FUNC_TOP, 16'hC0DE, 16'hFFFF, 4'b1111)); // unused code

    // --- random requests, mostly real operations, a few unused codes ---
    repeat (RANDOM_REQS) begin
      if ($urandom_range(0, 9) == 0) r.func = 5'($urandom_range(OP_DEC16 + 1, FUNC_TOP));
      else r.func = 5'($urandom_range(OP_ADD, OP_DEC16));
      r.operand_a = pick_operand();
      r.operand_b = pick_operand();
      r.flags_in  = 4'($urandom);
      issue(r);
    end
    req_valid <= 1'b0;

    // drain: let the count take in the last request, then wait for every
    // response and let the pipe settle
    @(posedge clk);
    waited = 0;
    while (pending_count != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== accumulator_alu_with_flags.f =====
sv/accalu_pkg.sv
sv/accalu_core.sv
sv/accumulator_alu_with_flags.sv
sv/accalu_checker.sv
dv/accumulator_alu_with_flags_checker.sv
dv/accumulator_alu_with_flags_tb.sv
